// ===== rtl/core/jsu_pkg.sv =====
// Shared types, constants and decode functions for the JSON string unescape unit.
// Used by jsu_front, jsu_queue, jsu_back and json_string_unescape_unit.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

   // Saturation limit of the consumed-byte count; the count register is 16 bits wide.
   localparam logic [31:0] COUNT_LIMIT = 32'd65535;
   localparam logic [15:0] COUNT_CAP =
      (COUNT_LIMIT > 32'h0000_FFFF) ? 16'hFFFF : 16'(COUNT_LIMIT);

   // Default number of entries in the queue between front and back.
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

   // Result kinds as they appear on the result channel.
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_OK   = 2'd1;
   localparam logic [1:0] KIND_ERR  = 2'd2;

   // Characters with a meaning of their own.
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_SLASH  = 8'h2F;
   localparam logic [7:0] CHAR_LOW_B  = 8'h62;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_LOW_N  = 8'h6E;
   localparam logic [7:0] CHAR_LOW_R  = 8'h72;
   localparam logic [7:0] CHAR_LOW_T  = 8'h74;
   localparam logic [7:0] CHAR_LOW_U  = 8'h75;

   // UTF-8 encoding limits and markers.
   localparam logic [15:0] UTF8_ONE_MAX  = 16'h007F;
   localparam logic [15:0] UTF8_TWO_MAX  = 16'h07FF;
   localparam logic [7:0]  UTF8_LEAD_TWO = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD_THR = 8'hE0;
   localparam logic [7:0]  UTF8_CONT     = 8'h80;
   localparam logic [5:0]  UTF8_CONT_MSK = 6'h3F;

   typedef enum logic [1:0] {
      PH_QUOTE,
      PH_BODY,
      PH_ESC,
      PH_HEX
   } phase_type;

   // One entry of work handed from front to back: up to three data bytes,
   // then an optional status.
   typedef struct packed {
      logic [1:0]      num_bytes;
      logic [2:0][7:0] bytes;
      logic            has_status;
      logic [1:0]      status_kind;
      logic [15:0]     count;
   } cmd_type;

   typedef struct packed {
      logic [1:0]      num_bytes;
      logic [2:0][7:0] bytes;
   } utf8_type;

   typedef struct packed {
      logic       ok;
      logic [3:0] value;
   } nibble_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] value;
   } escape_type;

   function automatic nibble_type hex_digit(input logic [7:0] b);
      nibble_type r;
      r.ok    = 1'b0;
      r.value = b[3:0];
      if (b >= 8'h30 && b <= 8'h39) begin
         r.ok = 1'b1;
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         // Letters a..f carry 1..6 in the low nibble, so adding nine gives 10..15.
         r.ok    = 1'b1;
         r.value = b[3:0] + 4'd9;
      end
      return r;
   endfunction

   function automatic escape_type simple_escape(input logic [7:0] b);
      escape_type r;
      r.ok    = 1'b1;
      r.value = b;
      unique case (b) inside
         CHAR_QUOTE, CHAR_BSLASH, CHAR_SLASH: r.value = b;
         CHAR_LOW_B: r.value = 8'h08;
         CHAR_LOW_F: r.value = 8'h0C;
         CHAR_LOW_N: r.value = 8'h0A;
         CHAR_LOW_R: r.value = 8'h0D;
         CHAR_LOW_T: r.value = 8'h09;
         default:    r.ok    = 1'b0;
      endcase
      return r;
   endfunction

   function automatic utf8_type utf8_encode(input logic [15:0] cp);
      utf8_type r;
      r.bytes = '0;
      if (cp <= UTF8_ONE_MAX) begin
         r.num_bytes = 2'd1;
         r.bytes[0]  = cp[7:0];
      end else if (cp <= UTF8_TWO_MAX) begin
         r.num_bytes = 2'd2;
         r.bytes[0]  = UTF8_LEAD_TWO | {3'b000, cp[10:6]};
         r.bytes[1]  = UTF8_CONT | {2'b00, cp[5:0] & UTF8_CONT_MSK};
      end else begin
         r.num_bytes = 2'd3;
         r.bytes[0]  = UTF8_LEAD_THR | {4'b0000, cp[15:12]};
         r.bytes[1]  = UTF8_CONT | {2'b00, cp[11:6] & UTF8_CONT_MSK};
         r.bytes[2]  = UTF8_CONT | {2'b00, cp[5:0] & UTF8_CONT_MSK};
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jsu_front.sv =====
// Front part: parses one input word per accepted cycle and builds a queue work entry.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            accept,
   input  wire logic [7:0]      data_byte,
   input  wire logic            end_of_input,
   output jsu_pkg::cmd_type     cmd,
   output logic                 cmd_push
);

   jsu_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         hex_seen_ff, hex_seen_in;
   logic [15:0]        acc_ff, acc_in;
   logic [15:0]        count_ff, count_in;

   logic [15:0]         count_next;
   logic [15:0]         acc_shift;
   jsu_pkg::nibble_type nib;
   jsu_pkg::escape_type esc;
   jsu_pkg::utf8_type   enc;
   logic                done;
   logic [1:0]          done_kind;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= jsu_pkg::PH_QUOTE;
         hex_seen_ff <= 2'd0;
         acc_ff      <= 16'd0;
         count_ff    <= 16'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         hex_seen_ff <= hex_seen_in;
         acc_ff      <= acc_in;
         count_ff    <= count_in;
      end
   end

   always_comb begin
      count_next = (count_ff < jsu_pkg::COUNT_CAP) ? count_ff + 16'd1 : count_ff;
      nib        = jsu_pkg::hex_digit(data_byte);
      esc        = jsu_pkg::simple_escape(data_byte);
      acc_shift  = {acc_ff[11:0], nib.value};
      enc        = jsu_pkg::utf8_encode(acc_shift);

      phase_in    = phase_ff;
      hex_seen_in = hex_seen_ff;
      acc_in      = acc_ff;
      count_in    = count_next;
      done        = 1'b0;
      done_kind   = jsu_pkg::KIND_ERR;

      cmd             = '0;
      cmd.status_kind = jsu_pkg::KIND_ERR;

      unique case (phase_ff)
         jsu_pkg::PH_QUOTE: begin
            if (data_byte == jsu_pkg::CHAR_QUOTE) begin
               phase_in = jsu_pkg::PH_BODY;
            end else begin
               done = 1'b1;
            end
         end
         jsu_pkg::PH_BODY: begin
            if (data_byte == jsu_pkg::CHAR_QUOTE) begin
               done      = 1'b1;
               done_kind = jsu_pkg::KIND_OK;
            end else if (data_byte == jsu_pkg::CHAR_BSLASH) begin
               phase_in = jsu_pkg::PH_ESC;
            end else begin
               cmd.num_bytes = 2'd1;
               cmd.bytes[0]  = data_byte;
            end
         end
         jsu_pkg::PH_ESC: begin
            phase_in = jsu_pkg::PH_BODY;
            if (data_byte == jsu_pkg::CHAR_LOW_U) begin
               phase_in    = jsu_pkg::PH_HEX;
               hex_seen_in = 2'd0;
               acc_in      = 16'd0;
            end else if (esc.ok) begin
               cmd.num_bytes = 2'd1;
               cmd.bytes[0]  = esc.value;
            end else begin
               done = 1'b1;
            end
         end
         jsu_pkg::PH_HEX: begin
            if (!nib.ok) begin
               done = 1'b1;
            end else if (hex_seen_ff == 2'd3) begin
               cmd.num_bytes = enc.num_bytes;
               cmd.bytes     = enc.bytes;
               phase_in      = jsu_pkg::PH_BODY;
               hex_seen_in   = 2'd0;
               acc_in        = 16'd0;
            end else begin
               hex_seen_in = hex_seen_ff + 2'd1;
               acc_in      = acc_shift;
            end
         end
         default: begin
            phase_in = jsu_pkg::PH_QUOTE;
         end
      endcase

      // Running out of text inside the string is an error after this word's bytes.
      if (!done && end_of_input) begin
         done = 1'b1;
      end

      if (done) begin
         cmd.has_status  = 1'b1;
         cmd.status_kind = done_kind;
         cmd.count       = count_next;
         phase_in        = jsu_pkg::PH_QUOTE;
         hex_seen_in     = 2'd0;
         acc_in          = 16'd0;
         count_in        = 16'd0;
      end

      cmd_push = accept && (cmd.num_bytes != 2'd0 || cmd.has_status);
   end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_queue.sv =====
// Small first-in first-out queue of work entries between front and back.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue #(
   parameter int unsigned DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire jsu_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output jsu_pkg::cmd_type      pop_cmd,
   output logic                  full,
   output logic                  empty
);

   localparam int unsigned PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CntWidth = $clog2(DEPTH + 1);

   jsu_pkg::cmd_type      entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   always_comb begin
      full    = (count_ff == CntWidth'(DEPTH));
      empty   = (count_ff == '0);
      do_push = push && !full;
      do_pop  = pop && !empty;
      pop_cmd = entry_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/jsu_back.sv =====
// Back part: turns each work entry into result words in an output register, one per unstalled cycle.
// Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire jsu_pkg::cmd_type q_cmd,
   input  wire logic             q_empty,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [1:0]            rsp_kind,
   output logic [7:0]            rsp_byte,
   output logic [15:0]           rsp_count,
   output logic                  rsp_last
);

   jsu_pkg::cmd_type cmd_ff, cmd_in;
   logic             cmd_valid_ff, cmd_valid_in;
   logic [1:0]       idx_ff, idx_in;

   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_kind_ff, out_kind_in;
   logic [7:0]       out_byte_ff, out_byte_in;
   logic [15:0]      out_count_ff, out_count_in;
   logic             out_last_ff, out_last_in;

   logic             out_free;
   logic             take_cur;
   logic [2:0]       cur_total;
   logic             cur_final;
   logic             need_new;

   always_comb begin
      out_free  = !out_valid_ff || rsp_ready;
      take_cur  = out_free && cmd_valid_ff;
      cur_total = {1'b0, cmd_ff.num_bytes} + {2'b00, cmd_ff.has_status};
      cur_final = ({1'b0, idx_ff} + 3'd1) == cur_total;
      need_new  = !cmd_valid_ff || (take_cur && cur_final);
      q_pop     = need_new && !q_empty;

      cmd_in       = cmd_ff;
      cmd_valid_in = cmd_valid_ff;
      idx_in       = idx_ff;
      if (q_pop) begin
         cmd_in       = q_cmd;
         cmd_valid_in = 1'b1;
         idx_in       = 2'd0;
      end else if (need_new) begin
         cmd_valid_in = 1'b0;
      end else if (take_cur) begin
         idx_in = idx_ff + 2'd1;
      end

      // Data bytes come first, then the status if there is one.
      out_valid_in = out_free ? take_cur : out_valid_ff;
      out_kind_in  = out_kind_ff;
      out_byte_in  = out_byte_ff;
      out_count_in = out_count_ff;
      out_last_in  = out_last_ff;
      if (take_cur) begin
         out_last_in = cur_final;
         if (idx_ff < cmd_ff.num_bytes) begin
            out_kind_in  = jsu_pkg::KIND_BYTE;
            out_count_in = 16'd0;
            case (idx_ff)
               2'd0:    out_byte_in = cmd_ff.bytes[0];
               2'd1:    out_byte_in = cmd_ff.bytes[1];
               default: out_byte_in = cmd_ff.bytes[2];
            endcase
         end else begin
            out_kind_in  = cmd_ff.status_kind;
            out_byte_in  = 8'd0;
            out_count_in = cmd_ff.count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         cmd_valid_ff <= cmd_valid_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      out_kind_ff  <= out_kind_in;
      out_byte_ff  <= out_byte_in;
      out_count_ff <= out_count_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_byte  = out_byte_ff;
   assign rsp_count = out_count_ff;
   assign rsp_last  = out_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/json_string_unescape_unit.sv =====
// Top level of the JSON string unescape unit: front parser, work queue and result back end.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
`timescale 1ns / 1ps
`default_nettype none

// This unit decodes one JSON string literal from a stream of raw text bytes, one byte per
// word on the req_ channel, beginning at the opening double quote. Plain bytes come out as
// they are, the eight simple backslash escapes become single bytes, and a backslash-u escape
// with four hex digits becomes one to three UTF-8 bytes (surrogate pairs are not combined).
// A closing quote produces an ok status word; a bad opening byte, an unknown escape, a bad
// hex digit or req_tlast before the closing quote produces an error status word, and the
// bytes already delivered for that string must then be discarded. Status words carry the
// number of input bytes the string used, saturating at 65535. rsp_tlast marks the final
// result word caused by one input word; input words that cause no result (the opening quote,
// a backslash, the first three hex digits) produce nothing. After any status the unit waits
// for the next opening quote. Input words are accepted at one per cycle while the queue has
// room: the front parser handles each word in the cycle in which it is accepted and drops its
// results into a queue of QUEUE_DEPTH entries. The back end delivers one result word per
// cycle while rsp_tready is high, so the sustained rate is then one input word per cycle as
// long as each word causes at most one result; a backslash-u escape that expands to two or
// three bytes, plus a status, gives up to four result words, and the queue absorbs that
// burst. From an idle unit, a word's first result passes through the queue, the back end's
// command register and its output register. req_tready falls only when the queue is full.

module json_string_unescape_unit #(
   parameter int unsigned QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tlast,   // end_of_input

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // [7:0] out_byte, [23:8] consumed_count
   output logic [1:0]       rsp_tuser,   // [1:0] out_kind
   output logic             rsp_tlast    // last
);

   jsu_pkg::cmd_type front_cmd;
   jsu_pkg::cmd_type queue_cmd;
   logic             front_push;
   logic             queue_full;
   logic             queue_empty;
   logic             queue_pop;
   logic             req_accept;
   logic [7:0]       rsp_byte;
   logic [15:0]      rsp_count;

   assign req_tready = !queue_full;
   assign req_accept = req_tvalid && req_tready;

   // The front parser keeps the string state and turns each accepted word into one work
   // entry, or into none when the word produces no result.
   jsu_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_tdata),
      .end_of_input (req_tlast),
      .cmd          (front_cmd),
      .cmd_push     (front_push)
   );

   // The queue lets the parser keep taking words while the back end works off a
   // multi-byte expansion or waits on a stalled result channel.
   jsu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_cmd (front_cmd),
      .pop      (queue_pop),
      .pop_cmd  (queue_cmd),
      .full     (queue_full),
      .empty    (queue_empty)
   );

   // The back end walks each entry one result word at a time into its output register.
   jsu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_cmd     (queue_cmd),
      .q_empty   (queue_empty),
      .q_pop     (queue_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_kind  (rsp_tuser),
      .rsp_byte  (rsp_byte),
      .rsp_count (rsp_count),
      .rsp_last  (rsp_tlast)
   );

   assign rsp_tdata = {rsp_count, rsp_byte};

endmodule

`default_nettype wire

// ===== verif/json_unescape_checker.sv =====
// Scoreboard for the JSON string unescape unit: decodes every accepted text word on its own
// and compares each result word with the oldest decoded one. Depends on jsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module json_unescape_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [7:0]  req_tdata,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic [1:0]  rsp_tuser,
   input  wire logic        rsp_tlast,
   output int unsigned      fail_count,
   output int unsigned      words_pending
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic [15:0] count;
      logic        last;
   } result_word_type;

   jsu_pkg::phase_type parse_phase   = jsu_pkg::PH_QUOTE;
   logic [1:0]         digits_taken  = '0;
   logic [15:0]        code_point    = '0;
   logic [15:0]        string_length = '0;
   result_word_type    step_words[$];
   result_word_type    awaited_words[$];
   int unsigned        mismatches    = 0;

   // Bit 4 flags a valid hex digit, bits 3:0 hold its value.
   function automatic logic [4:0] hex_nibble(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return {1'b1, 4'(b - 8'h30)};
      if (b >= 8'h61 && b <= 8'h66) return {1'b1, 4'(b - 8'h57)};
      if (b >= 8'h41 && b <= 8'h46) return {1'b1, 4'(b - 8'h37)};
      return 5'd0;
   endfunction

   task automatic add_word(input logic [1:0] kind, input logic [7:0] b,
                           input logic [15:0] count);
      result_word_type w;
      w.kind  = kind;
      w.data  = b;
      w.count = count;
      w.last  = 1'b0;
      step_words.insert(step_words.size(), w);
   endtask

   task automatic add_byte(input logic [7:0] b);
      add_word(jsu_pkg::KIND_BYTE, b, 16'd0);
   endtask

   task automatic add_utf8(input logic [15:0] cp);
      if (cp <= jsu_pkg::UTF8_ONE_MAX) begin
         add_byte(cp[7:0]);
      end else if (cp <= jsu_pkg::UTF8_TWO_MAX) begin
         add_byte({3'b110, cp[10:6]});
         add_byte({2'b10, cp[5:0]});
      end else begin
         add_byte({4'b1110, cp[15:12]});
         add_byte({2'b10, cp[11:6]});
         add_byte({2'b10, cp[5:0]});
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic eoi);
      logic       closing;
      logic [1:0] status;
      logic [4:0] digit;
      closing = 1'b0;
      status  = jsu_pkg::KIND_ERR;
      step_words.delete();
      if (string_length < jsu_pkg::COUNT_CAP) string_length = string_length + 16'd1;
      case (parse_phase)
         jsu_pkg::PH_QUOTE: begin
            if (b == jsu_pkg::CHAR_QUOTE) parse_phase = jsu_pkg::PH_BODY;
            else closing = 1'b1;
         end
         jsu_pkg::PH_BODY: begin
            if (b == jsu_pkg::CHAR_QUOTE) begin
               closing = 1'b1;
               status  = jsu_pkg::KIND_OK;
            end else if (b == jsu_pkg::CHAR_BSLASH) begin
               parse_phase = jsu_pkg::PH_ESC;
            end else begin
               add_byte(b);
            end
         end
         jsu_pkg::PH_ESC: begin
            parse_phase = jsu_pkg::PH_BODY;
            case (b) inside
               jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BSLASH, jsu_pkg::CHAR_SLASH: add_byte(b);
               jsu_pkg::CHAR_LOW_B: add_byte(8'h08);
               jsu_pkg::CHAR_LOW_F: add_byte(8'h0C);
               jsu_pkg::CHAR_LOW_N: add_byte(8'h0A);
               jsu_pkg::CHAR_LOW_R: add_byte(8'h0D);
               jsu_pkg::CHAR_LOW_T: add_byte(8'h09);
               jsu_pkg::CHAR_LOW_U: begin
                  parse_phase  = jsu_pkg::PH_HEX;
                  digits_taken = '0;
                  code_point   = '0;
               end
               default: closing = 1'b1;
            endcase
         end
         default: begin
            digit = hex_nibble(b);
            if (!digit[4]) begin
               closing = 1'b1;
            end else begin
               code_point = {code_point[11:0], digit[3:0]};
               if (digits_taken == 2'd3) begin
                  add_utf8(code_point);
                  parse_phase  = jsu_pkg::PH_BODY;
                  digits_taken = '0;
                  code_point   = '0;
               end else begin
                  digits_taken = digits_taken + 2'd1;
               end
            end
         end
      endcase
      // The end of the text inside a string is an error, after the word's own bytes.
      if (!closing && eoi) closing = 1'b1;
      if (closing) begin
         add_word(status, 8'd0, string_length);
         parse_phase   = jsu_pkg::PH_QUOTE;
         digits_taken  = '0;
         code_point    = '0;
         string_length = '0;
      end
      if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      foreach (step_words[i]) awaited_words.insert(awaited_words.size(), step_words[i]);
   endtask

   always @(posedge clock) begin
      result_word_type seen;
      result_word_type want;
      if (reset) begin
         parse_phase   = jsu_pkg::PH_QUOTE;
         digits_taken  = '0;
         code_point    = '0;
         string_length = '0;
         awaited_words.delete();
      end else begin
         if (req_tvalid && req_tready) decode_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            seen = '{rsp_tuser, rsp_tdata[7:0], rsp_tdata[23:8], rsp_tlast};
            if (awaited_words.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result word: kind %0d byte %02h count %0d last %0b",
                        $time, seen.kind, seen.data, seen.count, seen.last);
            end else begin
               want = awaited_words.pop_front();
               if (seen.kind !== want.kind || seen.data !== want.data ||
                   seen.count !== want.count || seen.last !== want.last) begin
                  mismatches++;
                  $display({"%0t: result mismatch: expected kind %0d byte %02h count %0d ",
                            "last %0b, actual kind %0d byte %02h count %0d last %0b"},
                           $time, want.kind, want.data, want.count, want.last,
                           seen.kind, seen.data, seen.count, seen.last);
               end
            end
         end
      end
      words_pending <= awaited_words.size();
      fail_count    <= mismatches;
   end

endmodule

`default_nettype wire

// ===== verif/tb_json_string_unescape_unit.sv =====
// Testbench top for the JSON string unescape unit: builds text streams, drives them in bursts
// and gives the verdict. Depends on jsu_pkg, json_unescape_checker and the unit itself.
`timescale 1ns / 1ps
`default_nettype none

module tb_json_string_unescape_unit;

   typedef struct packed {
      logic [7:0] data;
      logic       eoi;
   } text_byte_type;

   // Ways in which a random string is spoiled on purpose.
   typedef enum {
      FLAW_NONE,
      FLAW_OPENING,
      FLAW_ESCAPE,
      FLAW_HEX,
      FLAW_EARLY_END
   } flaw_type;

   // Behaviors of the result receiver; each holds for a random span of cycles.
   typedef enum {
      READY_ALWAYS,
      READY_MOSTLY,
      READY_HALF,
      READY_PERIODIC
   } ready_mode_type;

   localparam int unsigned RANDOM_ITEMS = 320;
   localparam int unsigned DRAIN_CYCLES = 20;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] data_byte
   logic        req_tlast  = 1'b0; // end_of_input
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // [7:0] out_byte, [23:8] consumed_count
   logic [1:0]  rsp_tuser;         // [1:0] out_kind
   logic        rsp_tlast;         // last
   int unsigned fail_count;
   int unsigned words_pending;

   text_byte_type  text_q[$];
   int unsigned    burst_left = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int unsigned    ready_span = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   json_string_unescape_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   json_unescape_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   // The receiver switches between always ready, light and heavy random stalls, and a
   // periodic stall, so that back pressure lands on every phase of a multi-byte expansion.
   always @(posedge clock) begin
      if (ready_span == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         ready_span <= $urandom_range(16, 128);
      end else begin
         ready_span <= ready_span - 1;
      end
      case (ready_mode)
         READY_ALWAYS: rsp_tready <= 1'b1;
         READY_MOSTLY: rsp_tready <= ($urandom_range(0, 3) != 0);
         READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
         default:      rsp_tready <= (ready_span % 5 != 0);
      endcase
   end

   task automatic queue_byte(input logic [7:0] data, input logic eoi);
      text_byte_type entry;
      entry.data = data;
      entry.eoi  = eoi;
      text_q.insert(text_q.size(), entry);
   endtask

   // Any byte that stands for itself inside a string.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == jsu_pkg::CHAR_QUOTE || b == jsu_pkg::CHAR_BSLASH);
      return b;
   endfunction

   function automatic logic [7:0] escape_letter(input int unsigned idx);
      case (idx)
         0:       return jsu_pkg::CHAR_QUOTE;
         1:       return jsu_pkg::CHAR_BSLASH;
         2:       return jsu_pkg::CHAR_SLASH;
         3:       return jsu_pkg::CHAR_LOW_B;
         4:       return jsu_pkg::CHAR_LOW_F;
         5:       return jsu_pkg::CHAR_LOW_N;
         6:       return jsu_pkg::CHAR_LOW_R;
         default: return jsu_pkg::CHAR_LOW_T;
      endcase
   endfunction

   function automatic logic [7:0] bad_escape_letter();
      logic [7:0] b;
      logic       known;
      do begin
         b     = 8'($urandom_range(0, 255));
         known = (b == jsu_pkg::CHAR_LOW_U);
         for (int unsigned i = 0; i < 8; i++) if (b == escape_letter(i)) known = 1'b1;
      end while (known);
      return b;
   endfunction

   function automatic logic [7:0] bad_hex_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
             (b >= 8'h41 && b <= 8'h46));
      return b;
   endfunction

   // Hex digit as text; letters come in upper or lower case at random.
   function automatic logic [7:0] hex_char(input logic [3:0] nibble);
      if (nibble < 4'd10) return 8'h30 + 8'(nibble);
      if ($urandom_range(0, 1) == 0) return 8'h41 + 8'(nibble - 4'd10);
      return 8'h61 + 8'(nibble - 4'd10);
   endfunction

   task automatic queue_unicode(input logic [15:0] cp);
      queue_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
      queue_byte(jsu_pkg::CHAR_LOW_U, 1'b0);
      queue_byte(hex_char(cp[15:12]), 1'b0);
      queue_byte(hex_char(cp[11:8]), 1'b0);
      queue_byte(hex_char(cp[7:4]), 1'b0);
      queue_byte(hex_char(cp[3:0]), 1'b0);
   endtask

   // Code points spread over the one, two and three byte encodings and their borders.
   function automatic logic [15:0] pick_code_point();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(16'h0000, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2: return 16'($urandom_range(16'h0800, 16'hFFFF));
         default: begin
            case ($urandom_range(0, 5))
               0:       return 16'h0000;
               1:       return 16'h007F;
               2:       return 16'h0080;
               3:       return 16'h07FF;
               4:       return 16'h0800;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   task automatic queue_element();
      case ($urandom_range(0, 9)) inside
         [0:4]: queue_byte(plain_byte(), 1'b0);
         [5:6]: begin
            queue_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
            queue_byte(escape_letter($urandom_range(0, 7)), 1'b0);
         end
         default: queue_unicode(pick_code_point());
      endcase
   endtask

   // One string literal: mostly well formed, now and then spoiled in one of several ways.
   task automatic compose_string();
      flaw_type    flaw;
      int unsigned elements;
      int unsigned flaw_at;
      int unsigned mark;
      int unsigned keep;
      logic [7:0]  b;
      flaw = FLAW_NONE;
      if ($urandom_range(0, 6) == 0) flaw = flaw_type'($urandom_range(1, 4));
      if (flaw == FLAW_OPENING) begin
         do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CHAR_QUOTE);
         queue_byte(b, 1'($urandom_range(0, 1)));
         return;
      end
      queue_byte(jsu_pkg::CHAR_QUOTE, 1'b0);
      elements = $urandom_range(0, 8);
      if (flaw == FLAW_EARLY_END && elements == 0) elements = 1;
      flaw_at = (flaw == FLAW_EARLY_END) ? $urandom_range(0, elements - 1)
                                         : $urandom_range(0, elements);
      for (int unsigned k = 0; k <= elements; k++) begin
         if (k == flaw_at && flaw == FLAW_ESCAPE) begin
            queue_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
            queue_byte(bad_escape_letter(), 1'b0);
            return;
         end
         if (k == flaw_at && flaw == FLAW_HEX) begin
            queue_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
            queue_byte(jsu_pkg::CHAR_LOW_U, 1'b0);
            repeat ($urandom_range(0, 3)) queue_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
            queue_byte(bad_hex_byte(), 1'b0);
            return;
         end
         if (k < elements) begin
            mark = text_q.size();
            queue_element();
            // The text may end anywhere inside an element, even right after a backslash.
            if (k == flaw_at && flaw == FLAW_EARLY_END) begin
               keep = $urandom_range(mark + 1, text_q.size());
               while (text_q.size() > keep) void'(text_q.pop_back());
               text_q[text_q.size() - 1].eoi = 1'b1;
               return;
            end
         end
      end
      queue_byte(jsu_pkg::CHAR_QUOTE, 1'($urandom_range(0, 3) == 0));
   endtask

   task automatic compose_strings(input int unsigned items);
      int unsigned produced;
      int unsigned start_size;
      produced = 0;
      while (produced < items) begin
         start_size = text_q.size();
         compose_string();
         produced += text_q.size() - start_size;
      end
   endtask

   // Sends the queued text in bursts of random length; most bursts are short, some long
   // enough to keep the unit busy without a single idle cycle on the input.
   task automatic drive_text();
      int unsigned gap;
      while (text_q.size() > 0) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_tvalid <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 200)
                                                     : $urandom_range(1, 12);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= text_q[0].data;
         req_tlast  <= text_q[0].eoi;
         @(posedge clock);
         while (!req_tready) @(posedge clock);
         void'(text_q.pop_front());
         burst_left--;
      end
      req_tvalid <= 1'b0;
   endtask

   // The pending count is registered in the checker, so the task lets it update before reading it.
   task automatic wait_for_results();
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A byte other than a quote where a string should open fails at once.
      queue_byte(8'hFF, 1'b0);
      // The extreme byte values pass through, code point zero becomes a zero byte, and a
      // closing quote that also ends the text gives only the ok status.
      queue_byte(jsu_pkg::CHAR_QUOTE, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'hFF, 1'b0);
      queue_unicode(16'h0000);
      queue_byte(jsu_pkg::CHAR_QUOTE, 1'b1);
      // An escape letter that JSON does not know.
      queue_byte(jsu_pkg::CHAR_QUOTE, 1'b0);
      queue_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
      queue_byte(8'h78, 1'b0);
      // A letter just past the hex range after a good upper-case digit.
      queue_byte(jsu_pkg::CHAR_QUOTE, 1'b0);
      queue_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
      queue_byte(jsu_pkg::CHAR_LOW_U, 1'b0);
      queue_byte(8'h46, 1'b0);
      queue_byte(8'h67, 1'b0);
      // The largest code point in mixed case, with the text ending on its last digit:
      // three UTF-8 bytes and then the error status from one word.
      queue_byte(jsu_pkg::CHAR_QUOTE, 1'b0);
      queue_byte(jsu_pkg::CHAR_BSLASH, 1'b0);
      queue_byte(jsu_pkg::CHAR_LOW_U, 1'b0);
      queue_byte(8'h66, 1'b0);
      queue_byte(8'h46, 1'b0);
      queue_byte(8'h66, 1'b0);
      queue_byte(8'h46, 1'b1);
      // The text ends on the opening quote itself.
      queue_byte(jsu_pkg::CHAR_QUOTE, 1'b1);
      drive_text();

      // Hold the input until every result of the directed strings is out.
      wait_for_results();

      compose_strings(RANDOM_ITEMS / 2);
      drive_text();
      wait_for_results();

      compose_strings(RANDOM_ITEMS / 2);
      drive_text();

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, even with every stall at its worst.
   initial begin
      #20_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire

// ===== json_string_unescape_unit.f =====
rtl/core/jsu_pkg.sv
rtl/core/jsu_front.sv
rtl/core/jsu_queue.sv
rtl/core/jsu_back.sv
rtl/core/json_string_unescape_unit.sv
verif/json_unescape_checker.sv
verif/tb_json_string_unescape_unit.sv
